### rtl/i2cseq_pkg.sv
// Shared types and constants for the I2C master register sequencer.
// Used by i2cseq_ctrl and i2c_master_register_sequencer; no dependencies.
package i2cseq_pkg;

    // Transaction phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BUSY = 2'd1,
        PH_FAIL = 2'd2
    } phase_t;

    // Sequence step within a transaction
    localparam logic [2:0] STEP_ADDR      = 3'd0;
    localparam logic [2:0] STEP_REG       = 3'd1;
    localparam logic [2:0] STEP_PAYLOAD   = 3'd2;
    localparam logic [2:0] STEP_W_STOP    = 3'd3;
    localparam logic [2:0] STEP_R_RESTART = 3'd3;
    localparam logic [2:0] STEP_W_DONE    = 3'd4;
    localparam logic [2:0] STEP_R_RADDR   = 3'd4;
    localparam logic [2:0] STEP_R_ACK     = 3'd5;
    localparam logic [2:0] STEP_R_LAST    = 3'd6;
    localparam logic [2:0] STEP_R_DONE    = 3'd7;

    // Bus controller status codes, after masking
    localparam logic [7:0] ST_MASK        = 8'hF8;
    localparam logic [7:0] S_START        = 8'h08;
    localparam logic [7:0] S_REP_START    = 8'h10;
    localparam logic [7:0] S_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] S_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] S_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] S_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] S_MR_DATA_NACK = 8'h58;

    localparam logic [7:0] AUTO_INC = 8'h80;

    // Bus commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_NACK  = 3'd3;
    localparam logic [2:0] CMD_ACK   = 3'd4;

    // Action codes
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_EVENT   = 1'b1;

    typedef struct packed {
        logic       action;
        logic       req_read;
        logic [7:0] device_address;
        logic [6:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic [7:0] bus_status;
        logic [7:0] received_byte;
    } item_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] bus_command;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] data_index;
        logic       done_res;
        logic       failed;
        logic [7:0] error_code;
    } result_t;

endpackage

### rtl/i2c_master_register_sequencer.sv
// Top level of the I2C master register sequencer: input and result registers.
// Depends on i2cseq_pkg and i2cseq_ctrl.
//
//  channel | handshake            | carries
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | request or bus status event
//  out     | out_valid / out_ready| command, tx/rx byte, index, done, failure
//
//  An item is accepted into the input register; its result is computed by
//  the combinational step logic between the two registers and held in the
//  result register, from which it is taken when out_valid and out_ready are high.
//  One item per cycle is sustained while out_ready is high; with out_ready low
//  and the result register full, the flow stalls.
//  Reset clears both valid flags and the transaction state to idle.
//  A stalled result holds the input register; in_ready drops only when both
//  registers are full and out_ready is low.
module i2c_master_register_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic       req_read,
    input  logic [7:0] device_address,
    input  logic [6:0] register_address,
    input  logic [7:0] byte_count,
    input  logic [7:0] write_byte,
    input  logic [7:0] bus_status,
    input  logic [7:0] received_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       accepted,
    output logic [2:0] bus_command,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       rx_valid,
    output logic [7:0] rx_byte,
    output logic [7:0] data_index,
    output logic       done_res,
    output logic       failed,
    output logic [7:0] error_code
);
    import i2cseq_pkg::*;

    logic    item_vld_reg;
    item_t   item_reg;
    logic    res_vld_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;

    // Move an item from the input register to the result register
    assign advance  = item_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || advance;

    i2cseq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .result  (res_next)
    );

    // Track occupancy of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_vld_reg <= in_valid;
            if (advance)
                res_vld_reg <= 1'b1;
            else if (out_ready)
                res_vld_reg <= 1'b0;
        end
    end

    // Load payloads
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.action           <= action;
            item_reg.req_read         <= req_read;
            item_reg.device_address   <= device_address;
            item_reg.register_address <= register_address;
            item_reg.byte_count       <= byte_count;
            item_reg.write_byte       <= write_byte;
            item_reg.bus_status       <= bus_status;
            item_reg.received_byte    <= received_byte;
        end
        if (advance)
            res_reg <= res_next;
    end

    // Drive the result ports
    assign out_valid   = res_vld_reg;
    assign accepted    = res_reg.accepted;
    assign bus_command = res_reg.bus_command;
    assign tx_valid    = res_reg.tx_valid;
    assign tx_byte     = res_reg.tx_byte;
    assign rx_valid    = res_reg.rx_valid;
    assign rx_byte     = res_reg.rx_byte;
    assign data_index  = res_reg.data_index;
    assign done_res    = res_reg.done_res;
    assign failed      = res_reg.failed;
    assign error_code  = res_reg.error_code;

endmodule

### rtl/i2cseq_ctrl.sv
// Transaction state and per-item step logic of the I2C register sequencer.
// Depends on i2cseq_pkg.
module i2cseq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  i2cseq_pkg::item_t item,
    output i2cseq_pkg::result_t result
);
    import i2cseq_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [2:0] step_reg, step_next;
    logic       is_read_reg;
    logic [7:0] dev_addr_reg;
    logic [6:0] reg_addr_reg;
    logic [7:0] total_reg;
    logic [7:0] byte_index_reg, byte_index_next;
    logic [7:0] last_error_reg, last_error_next;

    logic       start;
    logic       go_idle;
    logic       go_fail;
    logic [7:0] st;
    logic [7:0] cnt;
    logic [7:0] idx_inc;
    logic       last_tx;
    logic       last_rx;
    result_t    res;

    // Decode the item against the current step
    always_comb
    begin
        st              = item.bus_status & ST_MASK;
        cnt             = (total_reg == 8'd0) ? 8'd1 : total_reg;
        idx_inc         = byte_index_reg + 8'd1;
        last_tx         = (idx_inc >= cnt);
        last_rx         = (({1'b0, idx_inc} + 9'd1) >= {1'b0, cnt});
        res             = '0;
        start           = 1'b0;
        go_idle         = 1'b0;
        go_fail         = 1'b0;
        step_next       = step_reg;
        byte_index_next = byte_index_reg;

        if (item.action == ACT_REQUEST)
        begin
            if (phase_reg == PH_IDLE)
            begin
                start           = 1'b1;
                res.accepted    = 1'b1;
                res.bus_command = CMD_START;
                step_next       = STEP_ADDR;
                byte_index_next = 8'd0;
            end
        end
        else if (phase_reg == PH_BUSY)
        begin
            case (step_reg)
                STEP_ADDR:
                begin
                    if (st == S_START)
                    begin
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = dev_addr_reg;
                        res.bus_command = CMD_NACK;
                        step_next       = STEP_REG;
                    end
                    else
                        go_fail = 1'b1;
                end
                STEP_REG:
                begin
                    if (st == S_MT_SLA_ACK)
                    begin
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = AUTO_INC | {1'b0, reg_addr_reg};
                        res.bus_command = CMD_NACK;
                        step_next       = STEP_PAYLOAD;
                    end
                    else
                        go_fail = 1'b1;
                end
                default:
                begin
                    if (!is_read_reg)
                    begin
                        if (step_reg == STEP_PAYLOAD && st == S_MT_DATA_ACK)
                        begin
                            res.tx_valid    = 1'b1;
                            res.tx_byte     = item.write_byte;
                            res.data_index  = byte_index_reg;
                            res.bus_command = CMD_NACK;
                            byte_index_next = idx_inc;
                            if (last_tx)
                                step_next = STEP_W_STOP;
                        end
                        else if (step_reg == STEP_W_STOP && st == S_MT_DATA_ACK)
                        begin
                            res.bus_command = CMD_STOP;
                            res.done_res    = 1'b1;
                            step_next       = STEP_W_DONE;
                            go_idle         = 1'b1;
                        end
                        else
                            go_fail = 1'b1;
                    end
                    else
                    begin
                        if (step_reg == STEP_PAYLOAD && st == S_MT_DATA_ACK)
                        begin
                            res.bus_command = CMD_START;
                            step_next       = STEP_R_RESTART;
                        end
                        else if (step_reg == STEP_R_RESTART && st == S_REP_START)
                        begin
                            res.tx_valid    = 1'b1;
                            res.tx_byte     = dev_addr_reg | 8'h01;
                            res.bus_command = CMD_NACK;
                            step_next       = STEP_R_RADDR;
                        end
                        else if (step_reg == STEP_R_RADDR && st == S_MR_SLA_ACK)
                        begin
                            if (cnt > 8'd1)
                            begin
                                res.bus_command = CMD_ACK;
                                step_next       = STEP_R_ACK;
                            end
                            else
                            begin
                                res.bus_command = CMD_NACK;
                                step_next       = STEP_R_LAST;
                            end
                        end
                        else if (step_reg == STEP_R_ACK && st == S_MR_DATA_ACK)
                        begin
                            res.rx_valid    = 1'b1;
                            res.rx_byte     = item.received_byte;
                            res.data_index  = byte_index_reg;
                            byte_index_next = idx_inc;
                            if (last_rx)
                            begin
                                res.bus_command = CMD_NACK;
                                step_next       = STEP_R_LAST;
                            end
                            else
                                res.bus_command = CMD_ACK;
                        end
                        else if (step_reg == STEP_R_LAST && st == S_MR_DATA_NACK)
                        begin
                            res.rx_valid    = 1'b1;
                            res.rx_byte     = item.received_byte;
                            res.data_index  = byte_index_reg;
                            byte_index_next = idx_inc;
                            res.bus_command = CMD_STOP;
                            res.done_res    = 1'b1;
                            step_next       = STEP_R_DONE;
                            go_idle         = 1'b1;
                        end
                        else
                            go_fail = 1'b1;
                    end
                end
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                    phase_next = PH_BUSY;
            end
            PH_BUSY:
            begin
                if (go_fail)
                    phase_next = PH_FAIL;
                else if (go_idle)
                    phase_next = PH_IDLE;
            end
            PH_FAIL:
                phase_next = PH_FAIL;
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // Capture the masked status on a read failure
    always_comb
    begin
        last_error_next = last_error_reg;
        if (go_fail && is_read_reg)
            last_error_next = st;
    end

    // Drive the result fields
    always_comb
    begin
        result            = res;
        result.failed     = (phase_next == PH_FAIL);
        result.error_code = last_error_next;
    end

    // Hold the transaction state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            step_reg       <= STEP_ADDR;
            is_read_reg    <= 1'b0;
            dev_addr_reg   <= 8'd0;
            reg_addr_reg   <= 7'd0;
            total_reg      <= 8'd0;
            byte_index_reg <= 8'd0;
            last_error_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            byte_index_reg <= byte_index_next;
            last_error_reg <= last_error_next;
            if (start)
            begin
                is_read_reg  <= item.req_read;
                dev_addr_reg <= item.device_address;
                reg_addr_reg <= item.register_address;
                total_reg    <= item.byte_count;
            end
        end
    end

endmodule
